[sv/tpw_pkg.sv]
`timescale 1ns / 1ps
package tpw_pkg;

    // Defaults for the top-level parameters.
    localparam int PHASE_BITS_DEF = 24;
    localparam int OUT_BITS_DEF   = 16;

    // Dimensions above this are clamped before halving.
    localparam int MAX_DIM = 1024;

    localparam int DIM_W      = 11;
    localparam int COORD_W    = 10;
    localparam int OFF_W      = COORD_W + 1;
    localparam int CENTER_W   = COORD_W;
    localparam int IN_TDATA_W = ((2 * COORD_W + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 3;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1024);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH    = 3'd0,
        CFG_HEIGHT   = 3'd1,
        CFG_STEP_X   = 3'd2,
        CFG_STEP_Y   = 3'd3,
        CFG_TILT     = 3'd4
    } t_cfg_idx;

    // Rotation datapath: Q30 vectors, Q32 angle in turns, one guard bit.
    localparam int CORDIC_STEPS = 28;
    localparam int CORD_W       = 33;
    localparam logic signed [CORD_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

    localparam logic [31:0] ATAN_TURNS_Q32 [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5
    };

    typedef struct packed {
        logic                      valid;
        logic                      zero;   // residual angle is zero
        logic [1:0]                quad;
        logic signed [CORD_W-1:0]  x;
        logic signed [CORD_W-1:0]  y;
        logic signed [CORD_W-1:0]  z;
    } t_cordic;

endpackage

[sv/tpw_cordic_stage.sv]
`timescale 1ns / 1ps
module tpw_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  tpw_pkg::t_cordic i_st,
    output tpw_pkg::t_cordic o_st
);
    import tpw_pkg::*;

    localparam logic signed [CORD_W-1:0] ATAN = CORD_W'(ATAN_TURNS_Q32[STEP]);

    t_cordic r_st;
    t_cordic n_st;

    logic signed [CORD_W-1:0] dx;
    logic signed [CORD_W-1:0] dy;

    // Arithmetic shift rounds toward minus infinity.
    assign dx = i_st.y >>> STEP;
    assign dy = i_st.x >>> STEP;

    always_comb begin
        n_st = i_st;
        if (!i_st.z[CORD_W-1]) begin
            n_st.x = i_st.x - dx;
            n_st.y = i_st.y + dy;
            n_st.z = i_st.z - ATAN;
        end else begin
            n_st.x = i_st.x + dx;
            n_st.y = i_st.y - dy;
            n_st.z = i_st.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.valid <= 1'b0;
        end else if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

[sv/tilted_plane_wave_phasor_core.sv]
`timescale 1ns / 1ps
// Tilted plane-wave phasor: for each pixel (column, row) gives cos/sin of
//   phase = step_x*(column - width/2) + step_y*(row - height/2)  (mod 1 turn)
// negated when tilt_back is set, as signed Q1.(OUT_BITS-1) values.
// Input stream (s side): tdata = {row, column}, one item per coordinate.
// Output stream (m side): tdata = {imag_part, real_part}, one item per input.
// Config: write i_cfg_we with i_cfg_idx / i_cfg_data; only while idle.
// Path: an accepted input item passes offset, multiply, phase, 28 rotation
// stages and output rounding into the output register, then shows on o_m_tvalid.
// Throughput: one item per cycle unless stalled; each rotation stage is one CORDIC
// iteration, each product has its own multiplier, so no shared unit sets the rate.
// Stall: a one-deep skid register sits behind the output register. When the
// receiver holds off, the item arriving from the pipe lands in the skid and
// the whole pipe then freezes; o_s_tready is the registered "skid empty".
// Reset (synchronous, active low) empties the pipe and loads register reset
// values: width 1024, height 1024, steps 0, tilt_back 0.
module tilted_plane_wave_phasor_core #(
    parameter int PHASE_BITS = tpw_pkg::PHASE_BITS_DEF,
    parameter int OUT_BITS   = tpw_pkg::OUT_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // config write port
    input  logic                                  i_cfg_we,
    input  logic [tpw_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [PHASE_BITS-1:0]                 i_cfg_data,
    // input stream; tdata from bit 0: column[9:0], row[19:10], zero pad
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [tpw_pkg::IN_TDATA_W-1:0]        i_s_tdata,
    // output stream; tdata from bit 0: real_part, imag_part, zero pad
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [((2*OUT_BITS+7)/8)*8-1:0]       o_m_tdata
);
    import tpw_pkg::*;

    localparam int OUT_TDATA_W = ((2 * OUT_BITS + 7) / 8) * 8;
    localparam int PROD_W      = PHASE_BITS + OFF_W;
    localparam int SH          = 31 - OUT_BITS;
    localparam logic signed [CORD_W:0] RND  = (CORD_W+1)'(1) <<< (SH - 1);
    localparam logic signed [CORD_W:0] OMAX = ((CORD_W+1)'(1) <<< (OUT_BITS - 1)) - 1;
    localparam logic signed [CORD_W:0] OMIN = -OMAX - 1;

    // Q30 -> Q1.(OUT_BITS-1), round half up, saturate.
    function automatic logic [OUT_BITS-1:0] to_out(input logic signed [CORD_W-1:0] v);
        logic signed [CORD_W:0] s;
        logic signed [CORD_W:0] r;
        s = {v[CORD_W-1], v} + RND;
        r = s >>> SH;
        if (r > OMAX) begin
            r = OMAX;
        end else if (r < OMIN) begin
            r = OMIN;
        end
        return r[OUT_BITS-1:0];
    endfunction

    // ---------------- configuration registers ----------------
    logic [DIM_W-1:0]             r_width;
    logic [DIM_W-1:0]             r_height;
    logic signed [PHASE_BITS-1:0] r_step_x;
    logic signed [PHASE_BITS-1:0] r_step_y;
    logic                         r_tilt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_RESET;
            r_height <= DIM_RESET;
            r_step_x <= '0;
            r_step_y <= '0;
            r_tilt   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                CFG_STEP_X: r_step_x <= i_cfg_data;
                CFG_STEP_Y: r_step_y <= i_cfg_data;
                CFG_TILT:   r_tilt   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Centers: clamp to MAX_DIM, then halve. Static between config writes.
    logic [CENTER_W-1:0] cx;
    logic [CENTER_W-1:0] cy;

    always_comb begin
        cx = (r_width  > DIM_W'(MAX_DIM)) ? CENTER_W'(MAX_DIM / 2) : CENTER_W'(r_width  >> 1);
        cy = (r_height > DIM_W'(MAX_DIM)) ? CENTER_W'(MAX_DIM / 2) : CENTER_W'(r_height >> 1);
    end

    // ---------------- pipeline control ----------------
    logic r_skid_v;
    logic en;

    assign en         = !r_skid_v;
    assign o_s_tready = en;

    // ---------------- stage 1: offsets from center ----------------
    logic                    r_s1_v;
    logic signed [OFF_W-1:0] r_offx;
    logic signed [OFF_W-1:0] r_offy;
    logic [COORD_W-1:0]      in_col;
    logic [COORD_W-1:0]      in_row;

    assign in_col = i_s_tdata[COORD_W-1:0];
    assign in_row = i_s_tdata[2*COORD_W-1:COORD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_s_tvalid;
            r_offx <= signed'({1'b0, in_col}) - signed'({1'b0, cx});
            r_offy <= signed'({1'b0, in_row}) - signed'({1'b0, cy});
        end
    end

    // ---------------- stage 2: step products, low bits only ----------------
    logic                    r_s2_v;
    logic [PHASE_BITS-1:0]   r_px;
    logic [PHASE_BITS-1:0]   r_py;
    logic signed [PROD_W-1:0] prod_x;
    logic signed [PROD_W-1:0] prod_y;

    assign prod_x = r_step_x * r_offx;
    assign prod_y = r_step_y * r_offy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= r_s1_v;
            r_px   <= prod_x[PHASE_BITS-1:0];
            r_py   <= prod_y[PHASE_BITS-1:0];
        end
    end

    // ---------------- stage 3: phase, quadrant split, rotation seed ----------------
    logic [PHASE_BITS-1:0] phase_sum;
    logic [PHASE_BITS-1:0] phase;
    logic [PHASE_BITS-3:0] resid;
    t_cordic               n_s3;
    t_cordic               r_s3;

    always_comb begin
        phase_sum = r_px + r_py;
        phase     = r_tilt ? (~phase_sum + PHASE_BITS'(1)) : phase_sum;
        resid     = phase[PHASE_BITS-3:0];
        n_s3.valid = r_s2_v;
        n_s3.zero  = (resid == '0);
        n_s3.quad  = phase[PHASE_BITS-1:PHASE_BITS-2];
        n_s3.x     = CORDIC_GAIN_Q30;
        n_s3.y     = '0;
        n_s3.z     = CORD_W'(resid) << (32 - PHASE_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.valid <= 1'b0;
        end else if (en) begin
            r_s3 <= n_s3;
        end
    end

    // ---------------- rotation stages, one iteration each ----------------
    t_cordic cord [CORDIC_STEPS+1];

    assign cord[0] = r_s3;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        tpw_cordic_stage #(
            .STEP (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_st    (cord[k]),
            .o_st    (cord[k+1])
        );
    end

    // ---------------- output rounding and quadrant map ----------------
    t_cordic                 last;
    logic [OUT_BITS-1:0]     c_val;
    logic [OUT_BITS-1:0]     s_val;
    logic [OUT_BITS-1:0]     rc;
    logic [OUT_BITS-1:0]     rs;
    logic [2*OUT_BITS-1:0]   res;

    assign last = cord[CORDIC_STEPS];

    always_comb begin
        if (last.zero) begin
            // multiple of a right angle: exact (max, 0)
            c_val = OMAX[OUT_BITS-1:0];
            s_val = '0;
        end else begin
            c_val = to_out(last.x);
            s_val = to_out(last.y);
        end
        unique case (last.quad)
            2'd0: begin
                rc = c_val;
                rs = s_val;
            end
            2'd1: begin
                rc = -s_val;
                rs = c_val;
            end
            2'd2: begin
                rc = -c_val;
                rs = -s_val;
            end
            default: begin
                rc = s_val;
                rs = -c_val;
            end
        endcase
        res = {rs, rc};
    end

    // ---------------- output register and skid ----------------
    logic                  r_out_v;
    logic [2*OUT_BITS-1:0] r_out;
    logic [2*OUT_BITS-1:0] r_skid;
    logic                  push;

    assign push = en && last.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_m_tready) begin
            if (r_skid_v) begin
                r_out    <= r_skid;
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out    <= res;
                r_out_v  <= push;
            end
        end else if (push) begin
            r_skid   <= res;
            r_skid_v <= 1'b1;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = OUT_TDATA_W'(r_out);

endmodule
